// File: rtl/byte_machine_instruction_executor_unit_defines.svh
// assertion macros for the byte machine executor
`ifndef BYTE_MACHINE_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
`define BYTE_MACHINE_INSTRUCTION_EXECUTOR_UNIT_DEFINES_SVH
// implication checked on every clock edge outside reset
`define BMX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define BMX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

// File: rtl/bmx_pkg.sv
// shared types and constants of the byte machine executor
package bmx_pkg;
  localparam int unsigned ValW = 17;
  localparam int unsigned StW = 4;
  localparam logic [7:0] OpCount = 8'd39;
  localparam logic [7:0] NotTaken = 8'd255;

  typedef enum logic [3:0] {
    ST_OK = 4'd0, ST_STOP = 4'd1, ST_HALT = 4'd2, ST_BADOP = 4'd3, ST_BADREG = 4'd4,
    ST_BADADDR = 4'd5, ST_DIVZERO = 4'd6, ST_OVERFLOW = 4'd7, ST_STKFULL = 4'd8,
    ST_STKEMPTY = 4'd9, ST_UNSUP = 4'd10
  } status_e;

  typedef enum logic [1:0] {
    FLAG_POS = 2'd0, FLAG_EQ = 2'd1, FLAG_NEG = 2'd2
  } flag_e;

  typedef enum logic [7:0] {
    OP_ADD = 8'd0, OP_SUB = 8'd1, OP_MUL = 8'd2, OP_DIV = 8'd3, OP_MOD = 8'd4,
    OP_STP = 8'd5, OP_LDI = 8'd6, OP_ADR = 8'd7, OP_SUR = 8'd8, OP_INC = 8'd9,
    OP_DEC = 8'd10, OP_JMP = 8'd11, OP_CMP = 8'd12, OP_JE = 8'd13, OP_JG = 8'd14,
    OP_JGE = 8'd15, OP_JL = 8'd16, OP_JLE = 8'd17, OP_JNE = 8'd18, OP_LDM = 8'd19,
    OP_STI = 8'd20, OP_STR = 8'd21, OP_MULR = 8'd22, OP_DIVR = 8'd23,
    OP_MODR = 8'd24, OP_ADM = 8'd25, OP_SUBM = 8'd26, OP_MUM = 8'd27,
    OP_DUM = 8'd28, OP_AND = 8'd29, OP_OR = 8'd30, OP_XOR = 8'd31, OP_SHL = 8'd32,
    OP_SHR = 8'd33, OP_NOT = 8'd34, OP_CALL = 8'd35, OP_RET = 8'd36,
    OP_ALOC = 8'd37, OP_FREE = 8'd38, OP_BAD = 8'd255
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] lb;
    logic [7:0] rb;
  } instr_t;

  typedef struct packed {
    logic [ValW-1:0] value;
    logic [7:0]      next_ip;
    logic [1:0]      flags;
    logic [StW-1:0]  status;
  } result_t;
endpackage

// File: rtl/bmx_decode.sv
// front end: accepts instructions, classifies the opcode, two-entry queue
module bmx_decode import bmx_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [23:0] in_data_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output instr_t      q_instr_o
);
  instr_t     mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  instr_t     dec;
  logic       push, pop;

  always_comb begin
    dec.lb = in_data_i[15:8];
    dec.rb = in_data_i[23:16];
    if (in_data_i[7:0] < OpCount) dec.op = op_e'(in_data_i[7:0]);
    else dec.op = OP_BAD;
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_instr_o = mem_q[rp_q];
  assign push = in_valid_i && in_ready_o;
  assign pop = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= dec;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end
endmodule

// File: rtl/bmx_divider.sv
// 8-bit restoring divider, one quotient bit per cycle
module bmx_divider (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] dividend_i,
  input  logic [7:0] divisor_i,
  output logic       done_o,
  output logic [7:0] quot_o,
  output logic [7:0] rem_o
);
  logic [7:0] quot_q, rem_q, dsr_q;
  logic [3:0] cnt_q;
  logic       busy_q;
  logic [8:0] trial;

  assign trial = {rem_q, quot_q[7]} - {1'b0, dsr_q};
  assign quot_o = quot_q;
  assign rem_o = rem_q;
  assign done_o = busy_q && (cnt_q == 4'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= 4'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q <= 4'd8;
    end else if (busy_q) begin
      if (cnt_q == 4'd0) busy_q <= 1'b0;
      else cnt_q <= cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q <= 8'd0;
      dsr_q <= divisor_i;
    end else if (busy_q && cnt_q != 4'd0) begin
      if (!trial[8]) begin
        rem_q <= trial[7:0];
        quot_q <= {quot_q[6:0], 1'b1};
      end else begin
        rem_q <= {rem_q[6:0], quot_q[7]};
        quot_q <= {quot_q[6:0], 1'b0};
      end
    end
  end
endmodule

// File: rtl/bmx_execute.sv
// back end: machine state, instruction execution and result register
module bmx_execute import bmx_pkg::*; #(
  parameter int unsigned DataWords = 16,
  parameter int unsigned StackDepth = 32,
  parameter int unsigned RegCount = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       q_valid_i,
  output logic       q_ready_o,
  input  instr_t     q_instr_i,
  output logic       res_valid_o,
  input  logic       res_ready_i,
  output result_t    res_o
);
  `include "byte_machine_instruction_executor_unit_defines.svh"

  localparam int unsigned DAW = (DataWords > 1) ? $clog2(DataWords) : 1;
  localparam int unsigned SAW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned SLW = $clog2(StackDepth + 1);
  localparam int unsigned RAW = (RegCount > 1) ? $clog2(RegCount) : 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_DIV, S_EXEC, S_OUT} state_e;

  state_e     state_q;
  instr_t     ins_q;
  logic [7:0] code_len_q, ip_q;
  logic [7:0] regs_q [RegCount];
  logic [1:0] flags_q;
  logic [SLW-1:0] lvl_q;
  logic       halted_q;
  logic [DataWords-1:0] dvalid_q;
  logic [StackDepth-1:0] svalid_q;
  logic [7:0] dmem [DataWords];
  logic [7:0] smem [StackDepth];
  logic [7:0] m_q, pop_q;
  logic       res_valid_q;
  result_t    res_q;

  logic       lreg, raddr, laddr;
  logic [7:0] regl, regr, m_eff, nxt3, pop_eff;
  logic       div_start, div_done;
  logic [7:0] div_a, div_b, quot, rem;
  logic [15:0] prod;
  logic       exe_fire;

  logic l_ok, r_addr_ok, l_addr_ok;
  assign l_ok = 32'(ins_q.lb) < RegCount;
  assign r_addr_ok = 32'(ins_q.rb) < DataWords;
  assign l_addr_ok = 32'(ins_q.lb) < DataWords;
  assign lreg = l_ok;
  assign raddr = r_addr_ok;
  assign laddr = l_addr_ok;
  assign regl = l_ok ? regs_q[ins_q.lb[RAW-1:0]] : 8'd255;
  assign regr = (32'(ins_q.rb) < RegCount) ? regs_q[ins_q.rb[RAW-1:0]] : 8'd255;
  assign m_eff = m_q;
  assign pop_eff = pop_q;
  assign nxt3 = ip_q + 8'd3;

  assign div_b = (ins_q.op == OP_DUM) ? m_q : ins_q.rb;
  assign div_a = (ins_q.op == OP_DIV || ins_q.op == OP_MOD) ? ins_q.lb : regl;

  bmx_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .done_o(div_done), .quot_o(quot), .rem_o(rem)
  );

  assign q_ready_o = (state_q == S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o = res_q;
  assign exe_fire = (state_q == S_EXEC) && (!res_valid_q || res_ready_i);

  logic is_div;
  always_comb begin
    is_div = 1'b0;
    case (ins_q.op)
      OP_DIV, OP_MOD: is_div = (ins_q.rb != 8'd0);
      OP_DIVR, OP_MODR: is_div = lreg && (ins_q.rb != 8'd0);
      OP_DUM: is_div = lreg && raddr && (m_q != 8'd0);
      default: is_div = 1'b0;
    endcase
  end
  assign div_start = (state_q == S_READ) && is_div && !halted_q && (ip_q < code_len_q);
  assign prod = (ins_q.op == OP_MUL) ? ins_q.lb * ins_q.rb :
                (ins_q.op == OP_MULR) ? regl * ins_q.rb : regl * m_eff;

  // combinational execution of the held instruction
  logic [ValW-1:0] val;
  logic [3:0]      st;
  logic [7:0]      nxt;
  logic            wr_reg, wr_mem, push, pop, wr_flags;
  logic [7:0]      wr_data, mem_data, mem_addr;
  logic [1:0]      new_flags;
  logic signed [9:0] diff;
  always_comb begin
    val = '0; st = ST_OK; nxt = nxt3;
    wr_reg = 1'b0; wr_mem = 1'b0; push = 1'b0; pop = 1'b0; wr_flags = 1'b0;
    wr_data = '0; mem_data = '0; mem_addr = ins_q.rb;
    diff = $signed({2'b0, regl}) - $signed({2'b0, regr});
    new_flags = (diff == 10'sd0) ? FLAG_EQ : (diff < 0 ? FLAG_NEG : FLAG_POS);
    if (halted_q || ip_q >= code_len_q) begin
      st = ST_HALT;
    end else begin
      case (ins_q.op)
        OP_ADD: val = 17'(ins_q.lb) + 17'(ins_q.rb);
        OP_SUB: val = 17'(ins_q.lb) - 17'(ins_q.rb);
        OP_MUL: val = 17'(prod);
        OP_DIV: if (ins_q.rb == 0) st = ST_DIVZERO; else val = 17'(quot);
        OP_MOD: if (ins_q.rb == 0) st = ST_DIVZERO; else val = 17'(rem);
        OP_STP: begin st = ST_STOP; val = 17'(ins_q.lb); end
        OP_LDI: if (!lreg) st = ST_BADREG;
          else begin wr_reg = 1'b1; wr_data = ins_q.rb; val = 17'(ins_q.rb); end
        OP_ADR, OP_SUR, OP_INC, OP_DEC: if (!lreg) st = ST_BADREG;
          else begin
            wr_reg = 1'b1;
            case (ins_q.op)
              OP_ADR: wr_data = regl + ins_q.rb;
              OP_SUR: wr_data = regl - ins_q.rb;
              OP_INC: wr_data = regl + 8'd1;
              default: wr_data = regl - 8'd1;
            endcase
            val = 17'(wr_data);
          end
        OP_JMP: begin nxt = ins_q.lb; val = 17'(ins_q.lb); end
        OP_CMP: begin wr_flags = 1'b1; val = 17'(new_flags); end
        OP_JE, OP_JG, OP_JGE, OP_JL, OP_JLE, OP_JNE: begin
          logic tk;
          case (ins_q.op)
            OP_JE: tk = flags_q == FLAG_EQ;
            OP_JG: tk = flags_q == FLAG_POS;
            OP_JGE: tk = flags_q != FLAG_NEG;
            OP_JL: tk = flags_q == FLAG_NEG;
            OP_JLE: tk = flags_q != FLAG_POS;
            default: tk = flags_q != FLAG_EQ;
          endcase
          if (tk) begin nxt = ins_q.lb; val = 17'(ins_q.lb); end
          else val = 17'(NotTaken);
        end
        OP_LDM: if (!raddr) st = ST_BADADDR; else if (!lreg) st = ST_BADREG;
          else begin wr_reg = 1'b1; wr_data = m_eff; val = 17'(m_eff); end
        OP_STI: if (!laddr) st = ST_BADADDR;
          else begin wr_mem = 1'b1; mem_addr = ins_q.lb; mem_data = ins_q.rb;
            val = 17'(ins_q.rb); end
        OP_STR: if (!raddr) st = ST_BADADDR;
          else begin wr_mem = 1'b1; mem_data = regl; val = 17'(regl); end
        OP_MULR: if (!lreg) st = ST_BADREG; else val = 17'(prod[7:0]);
        OP_DIVR, OP_MODR: if (!lreg) st = ST_BADREG;
          else if (ins_q.rb == 0) st = ST_DIVZERO;
          else val = 17'((ins_q.op == OP_DIVR) ? quot : rem);
        OP_ADM, OP_SUBM, OP_MUM, OP_DUM: if (!lreg) st = ST_BADREG;
          else if (!raddr) st = ST_BADADDR;
          else begin
            case (ins_q.op)
              OP_ADM: begin val = 17'(regl) + 17'(m_eff);
                if (val > 17'd255) st = ST_OVERFLOW; end
              OP_SUBM: val = 17'(regl) - 17'(m_eff);
              OP_MUM: begin val = 17'(prod);
                if (prod > 16'd255) st = ST_OVERFLOW; end
              default: if (m_eff == 0) st = ST_DIVZERO; else val = 17'(quot);
            endcase
          end
        OP_AND: val = 17'(ins_q.lb & ins_q.rb);
        OP_OR: val = 17'(ins_q.lb | ins_q.rb);
        OP_XOR: val = 17'(ins_q.lb ^ ins_q.rb);
        OP_SHL: val = (ins_q.rb >= 8'd17) ? '0 : (17'(ins_q.lb) << ins_q.rb[4:0]);
        OP_SHR: val = (ins_q.rb >= 8'd8) ? '0 : 17'(ins_q.lb >> ins_q.rb[2:0]);
        OP_NOT: val = ~17'(ins_q.lb);
        OP_CALL: if (32'(lvl_q) >= StackDepth) st = ST_STKFULL;
          else begin push = 1'b1; nxt = ins_q.lb; val = 17'(ins_q.lb); end
        OP_RET: if (lvl_q == '0) st = ST_STKEMPTY;
          else begin pop = 1'b1; nxt = pop_eff; val = 17'(pop_eff); end
        OP_ALOC, OP_FREE: st = ST_UNSUP;
        default: st = ST_BADOP;
      endcase
    end
    if (st != ST_OK) begin
      nxt = ip_q;
      if (st != ST_STOP) val = '0;
      wr_reg = 1'b0; wr_mem = 1'b0; push = 1'b0; pop = 1'b0; wr_flags = 1'b0;
    end
  end

  logic [SAW-1:0] top_idx;
  assign top_idx = SAW'(lvl_q - SLW'(1));

  // store reads registered; an entry never written reads as zero
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && q_valid_i) begin
      m_q <= (32'(q_instr_i.rb) < DataWords && dvalid_q[q_instr_i.rb[DAW-1:0]]) ?
             dmem[q_instr_i.rb[DAW-1:0]] : 8'd0;
      pop_q <= (lvl_q != '0 && svalid_q[top_idx]) ? smem[top_idx] : 8'd0;
      ins_q <= q_instr_i;
    end
    if (exe_fire && wr_mem) dmem[mem_addr[DAW-1:0]] <= mem_data;
    if (exe_fire && push) smem[lvl_q[SAW-1:0]] <= nxt3;
    if (exe_fire) res_q <= '{value: val, next_ip: nxt, flags: wr_flags ?
                             new_flags : flags_q, status: st};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      code_len_q <= 8'd255;
      ip_q <= 8'd0;
      regs_q <= '{default: 8'd0};
      flags_q <= FLAG_POS;
      lvl_q <= '0;
      halted_q <= 1'b0;
      dvalid_q <= '0;
      svalid_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) code_len_q <= cfg_data_i;
      case (state_q)
        S_IDLE: if (q_valid_i) state_q <= S_READ;
        S_READ: state_q <= div_start ? S_DIV : S_EXEC;
        S_DIV: if (div_done) state_q <= S_EXEC;
        S_EXEC: if (!res_valid_q || res_ready_i) begin
          state_q <= S_OUT;
          res_valid_q <= 1'b1;
          if (st != ST_OK) halted_q <= 1'b1;
          else ip_q <= nxt;
          if (wr_reg) regs_q[ins_q.lb[RAW-1:0]] <= wr_data;
          if (wr_flags) flags_q <= new_flags;
          if (wr_mem) dvalid_q[mem_addr[DAW-1:0]] <= 1'b1;
          if (push) begin
            svalid_q[lvl_q[SAW-1:0]] <= 1'b1;
            lvl_q <= lvl_q + SLW'(1);
          end
          if (pop) begin
            svalid_q[top_idx] <= 1'b0;
            lvl_q <= lvl_q - SLW'(1);
          end
        end
        S_OUT: begin
          state_q <= S_IDLE;
          if (res_ready_i) res_valid_q <= 1'b0;
        end
        default: state_q <= S_IDLE;
      endcase
      if (state_q != S_EXEC && state_q != S_OUT && res_valid_q && res_ready_i)
        res_valid_q <= 1'b0;
    end
  end

  `BMX_ASSERT_IMP(a_lvl_range, clk_i, rst_ni, 1'b1, 32'(lvl_q) <= StackDepth, "stack level out of range")
  `BMX_ASSERT_NXT(a_halt_sticky, clk_i, rst_ni, halted_q, halted_q, "halted flag cleared")
  `BMX_ASSERT_IMP(a_div_idle, clk_i, rst_ni, state_q == S_DIV, !q_ready_o, "accepted while dividing")
  `BMX_ASSERT_NXT(a_ip_hold, clk_i, rst_ni, halted_q, $stable(ip_q), "pointer moved while halted")
endmodule

// File: rtl/byte_machine_instruction_executor_unit.sv
// top level of the byte machine instruction executor
// Executes one three-byte instruction per input transfer and returns one result transfer.
// The back end takes each instruction through its read, execute and output states, and the
// divide and modulo forms wait in a divide state for the bit-serial 8-bit divider; it takes
// no new instruction until it is idle again, a result held by the receiver stalls it, and
// a two-entry queue keeps accepting transfers in front of it until the queue is full.
module byte_machine_instruction_executor_unit import bmx_pkg::*; #(
  parameter int unsigned DATA_WORDS = 16,
  parameter int unsigned STACK_DEPTH = 32,
  parameter int unsigned REG_COUNT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // opcode, left_byte, right_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // value, next_ip, flags_out, status, zero pad
);
  logic   q_valid, q_ready;
  instr_t q_instr;
  result_t res;

  bmx_decode u_dec (
    .clk_i, .rst_ni, .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_data_i(s_axis_tdata), .q_valid_o(q_valid), .q_ready_i(q_ready),
    .q_instr_o(q_instr)
  );

  bmx_execute #(.DataWords(DATA_WORDS), .StackDepth(STACK_DEPTH), .RegCount(REG_COUNT))
  u_exe (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i, .q_valid_i(q_valid), .q_ready_o(q_ready),
    .q_instr_i(q_instr), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready),
    .res_o(res)
  );

  assign m_axis_tdata = {1'b0, res.status, res.flags, res.next_ip, res.value};
endmodule
